// ===== hw/rtl/tmarb_pkg.sv =====
// Shared types, widths and constants for the timestamp merge arbiter.
package tmarb_pkg;

	// Default number of merged sources and the size of one first-level compare group.
	localparam int DEFAULT_NUM_SOURCES = 8;
	localparam int GROUP_SIZE          = 4;

	// Field widths of one transfer.
	localparam int STAMP_W  = 64;
	localparam int SOURCE_W = 3;
	localparam int ACTION_W = 2;

	// Input tdata layout: source, value; padded to whole bytes.
	localparam int IN_SOURCE_LSB = 0;
	localparam int IN_VALUE_LSB  = IN_SOURCE_LSB + SOURCE_W;
	localparam int IN_USED_W     = IN_VALUE_LSB + STAMP_W;
	localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

	// Output tdata layout: grant_valid, grant_source, grant_stamp, all_done, blocked.
	localparam int OUT_GVALID_LSB  = 0;
	localparam int OUT_GSOURCE_LSB = OUT_GVALID_LSB + 1;
	localparam int OUT_GSTAMP_LSB  = OUT_GSOURCE_LSB + SOURCE_W;
	localparam int OUT_DONE_LSB    = OUT_GSTAMP_LSB + STAMP_W;
	localparam int OUT_BLOCKED_LSB = OUT_DONE_LSB + 1;
	localparam int OUT_USED_W      = OUT_BLOCKED_LSB + 1;
	localparam int OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

	// Extreme signed stamp values.
	localparam logic signed [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
	localparam logic signed [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};

	// Update kinds carried in the input tuser.
	typedef enum logic [ACTION_W-1:0] {
		ACT_HEAD  = 2'd0,
		ACT_MARK  = 2'd1,
		ACT_CLOSE = 2'd2,
		ACT_EVAL  = 2'd3
	} action_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;  // apply the accepted update to the source state
		logic eval;     // register the per-group minima
		logic commit;   // finish the merge decision and load the result register
	} tmarb_cmd_t;

endpackage

// ===== hw/rtl/tmarb_ctrl.sv =====
// Controller state machine: sequences accept, evaluation and result hand-off.
module tmarb_ctrl
	import tmarb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output tmarb_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Commands follow directly from the state and the handshakes.
	assign cmd.load_in = (state_q == ST_IDLE) && in_valid;
	assign cmd.eval    = (state_q == ST_EVAL);
	assign cmd.commit  = (state_q == ST_COMMIT) && out_free;

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/tmarb_datapath.sv =====
// Datapath: per-source state, two-stage minimum tree and the result register.
module tmarb_datapath
	import tmarb_pkg::*;
#(
	parameter int NUM_SOURCES = DEFAULT_NUM_SOURCES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tmarb_cmd_t             cmd,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  action_t                in_action,
	output logic [OUT_TDATA_W-1:0] out_tdata
);

	localparam int IDX_W      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int NUM_GROUPS = (NUM_SOURCES + GROUP_SIZE - 1) / GROUP_SIZE;

	// Per-source state.
	logic [NUM_SOURCES-1:0]          head_present_q;
	logic [NUM_SOURCES-1:0]          closed_q;
	logic signed [STAMP_W-1:0]       head_time_q [NUM_SOURCES];
	logic signed [STAMP_W-1:0]       low_mark_q  [NUM_SOURCES];

	// First-level group results, combinational and registered.
	logic [NUM_GROUPS-1:0]           grp_valid;
	logic [IDX_W-1:0]                grp_idx   [NUM_GROUPS];
	logic signed [STAMP_W-1:0]       grp_stamp [NUM_GROUPS];
	logic signed [STAMP_W-1:0]       grp_wm    [NUM_GROUPS];
	logic [NUM_GROUPS-1:0]           grp_pend;
	logic [NUM_GROUPS-1:0]           grp_valid_s1;
	logic [IDX_W-1:0]                grp_idx_s1   [NUM_GROUPS];
	logic signed [STAMP_W-1:0]       grp_stamp_s1 [NUM_GROUPS];
	logic signed [STAMP_W-1:0]       grp_wm_s1    [NUM_GROUPS];
	logic [NUM_GROUPS-1:0]           grp_pend_s1;

	// Final decision.
	logic                            best_valid;
	logic [IDX_W-1:0]                lead_src;
	logic signed [STAMP_W-1:0]       lead_stamp;
	logic signed [STAMP_W-1:0]       wm_min;
	logic                            pending;
	logic                            grant;

	logic [SOURCE_W-1:0]             in_source;
	logic signed [STAMP_W-1:0]       in_value;
	logic [OUT_TDATA_W-1:0]          out_tdata_q;

	assign in_source = in_tdata[IN_SOURCE_LSB +: SOURCE_W];
	assign in_value  = $signed(in_tdata[IN_VALUE_LSB +: STAMP_W]);

	// Control state of each source; a source index beyond the count matches no entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_present_q <= '0;
			closed_q       <= '0;
			for (int i = 0; i < NUM_SOURCES; i++) begin
				low_mark_q[i] <= STAMP_MIN;
			end
		end else begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				if (cmd.load_in && (int'(in_source) == i)) begin
					unique case (in_action)
						ACT_HEAD: begin
							if (!closed_q[i]) begin
								head_present_q[i] <= 1'b1;
							end
						end
						ACT_MARK: begin
							if (in_value > low_mark_q[i]) begin
								low_mark_q[i] <= in_value;
							end
						end
						ACT_CLOSE: begin
							closed_q[i] <= 1'b1;
						end
						ACT_EVAL: begin
						end
						default: begin
						end
					endcase
				end
			end
			if (cmd.commit && grant) begin
				head_present_q[lead_src] <= 1'b0;
			end
		end
	end

	// Head stamps are only read while their present bit is set.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_SOURCES; i++) begin
			if (cmd.load_in && (int'(in_source) == i) && (in_action == ACT_HEAD) &&
			    !closed_q[i]) begin
				head_time_q[i] <= in_value;
			end
		end
	end

	// First level: scan each group of sources in index order.
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_valid[g] = 1'b0;
			grp_idx[g]   = '0;
			grp_stamp[g] = STAMP_MAX;
			grp_wm[g]    = STAMP_MAX;
			grp_pend[g]  = 1'b0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (g * GROUP_SIZE + k < NUM_SOURCES) begin
					if (head_present_q[g * GROUP_SIZE + k]) begin
						grp_pend[g] = 1'b1;
						if (!grp_valid[g] || (head_time_q[g * GROUP_SIZE + k] < grp_stamp[g])) begin
							grp_valid[g] = 1'b1;
							grp_stamp[g] = head_time_q[g * GROUP_SIZE + k];
							grp_idx[g]   = IDX_W'(g * GROUP_SIZE + k);
						end
					end else if (!closed_q[g * GROUP_SIZE + k]) begin
						grp_pend[g] = 1'b1;
						if (low_mark_q[g * GROUP_SIZE + k] < grp_wm[g]) begin
							grp_wm[g] = low_mark_q[g * GROUP_SIZE + k];
						end
					end
				end
			end
		end
	end

	// Register the group results.
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			grp_valid_s1 <= grp_valid;
			grp_pend_s1  <= grp_pend;
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_idx_s1[g]   <= grp_idx[g];
				grp_stamp_s1[g] <= grp_stamp[g];
				grp_wm_s1[g]    <= grp_wm[g];
			end
		end
	end

	// Second level: combine groups in order, lower groups win ties.
	always_comb begin
		best_valid = 1'b0;
		lead_src   = '0;
		lead_stamp = STAMP_MAX;
		wm_min     = STAMP_MAX;
		pending    = |grp_pend_s1;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (grp_valid_s1[g] && (!best_valid || (grp_stamp_s1[g] < lead_stamp))) begin
				best_valid = 1'b1;
				lead_stamp = grp_stamp_s1[g];
				lead_src   = grp_idx_s1[g];
			end
			if (grp_wm_s1[g] < wm_min) begin
				wm_min = grp_wm_s1[g];
			end
		end
		grant = best_valid && (lead_stamp <= wm_min);
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_tdata_q                                  <= '0;
			out_tdata_q[OUT_GVALID_LSB]                  <= grant;
			out_tdata_q[OUT_GSOURCE_LSB +: SOURCE_W]     <= grant ?
				SOURCE_W'({{(SOURCE_W + 1){1'b0}}, lead_src}) : '0;
			out_tdata_q[OUT_GSTAMP_LSB +: STAMP_W]       <= grant ? lead_stamp : '0;
			out_tdata_q[OUT_DONE_LSB]                    <= !pending;
			out_tdata_q[OUT_BLOCKED_LSB]                 <= pending && !grant;
		end
	end

	assign out_tdata = out_tdata_q;

endmodule

// ===== hw/rtl/timestamp_merge_arbiter.sv =====
// Top level of the timestamp merge arbiter: controller, datapath and checks.
//
// The block merges NUM_SOURCES timestamped sources in stamp order. Each
// transfer on the s_axis channel updates one source (tuser selects the kind:
// present a head stamp, raise a watermark, close the source, or evaluate only)
// and then triggers one merge evaluation. Each evaluation returns exactly one
// transfer on m_axis: the granted source and stamp if the smallest present head
// is at or below the least watermark of all empty, open sources, plus the
// all_done and blocked flags.
// Sequence: an input is accepted in the idle state; the group-compare state
// registers the per-group minima of the two-level compare tree, and the
// final-compare state combines them, clears the granted head and loads the
// result register. The controller then returns to idle, and a new input is
// taken only in the idle state. Only one item is in flight at a time.
// If the receiver stalls, the result stays in the output register and the
// next input is still accepted; its evaluation then waits in the final step
// until the register drains. After reset no head is present, no source is
// closed and every watermark holds the most negative stamp.
module timestamp_merge_arbiter
	import tmarb_pkg::*;
#(
	parameter int NUM_SOURCES = DEFAULT_NUM_SOURCES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // source[2:0], value[66:3], zero pad
	input  logic [ACTION_W-1:0]    s_axis_tuser,   // action[1:0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // grant_valid[0], grant_source[3:1],
	                                               // grant_stamp[67:4], all_done[68],
	                                               // blocked[69], zero pad
);

	tmarb_cmd_t cmd;

	// Controller.
	tmarb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	// Datapath.
	tmarb_datapath #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_tdata  (s_axis_tdata),
		.in_action (action_t'(s_axis_tuser)),
		.out_tdata (m_axis_tdata)
	);

	// A grant never comes with the blocked flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[OUT_GVALID_LSB] && m_axis_tdata[OUT_BLOCKED_LSB]))
	else $error("grant and blocked reported together");

	// When all sources are done, nothing is granted and nothing is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[OUT_DONE_LSB]) |->
		(!m_axis_tdata[OUT_GVALID_LSB] && !m_axis_tdata[OUT_BLOCKED_LSB]))
	else $error("all_done reported with a grant or blocked");

	// Without a grant the source and stamp fields read zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[OUT_GVALID_LSB]) |->
		(m_axis_tdata[OUT_GSTAMP_LSB +: STAMP_W] == '0 &&
		 m_axis_tdata[OUT_GSOURCE_LSB +: SOURCE_W] == '0))
	else $error("grant fields nonzero without a grant");

	// One item at a time: after an input transfer the channel is not ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
	else $error("input accepted while an item is in flight");

endmodule
